// ===== hw/rtl/position_ledger_top_defines.svh =====
// ----------------------------------------------------------------------------
// Position ledger assertion macros
// Shared assertion wrappers for the position ledger checker.
// ----------------------------------------------------------------------------
`ifndef POSITION_LEDGER_TOP_DEFINES_SVH
`define POSITION_LEDGER_TOP_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define PL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("position ledger property violated");

// Checked on every rising edge, reset included.
`define PL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("position ledger property violated during reset");

`endif

// ===== hw/rtl/pl_pkg.sv =====
// ----------------------------------------------------------------------------
// Position ledger package
// Table size, request and result types, codes and internal interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pl_pkg;

  localparam int unsigned SYMBOL_COUNT = 1024;
  localparam int unsigned ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned CNT_W = ADDR_W + 1;
  localparam int unsigned RANGE_W = 17;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam int unsigned DIV_NUM_W = 88;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_Q_W = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [63:0] PL_MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PL_MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_BUY    = 2'd0,
    CMD_SELL   = 2'd1,
    CMD_PRICE  = 2'd2,
    CMD_EQUITY = 2'd3
  } pl_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSELL = 2'd1,
    ST_OVERFLOW = 2'd2
  } pl_status_e;

  typedef enum logic {
    REG_INITIAL_CASH = 1'b0,
    REG_COMMISSION   = 1'b1
  } pl_reg_e;

  typedef enum logic [3:0] {
    MOP_COST    = 4'd0,
    MOP_FEE_LO  = 4'd1,
    MOP_FEE_HI  = 4'd2,
    MOP_V_LO    = 4'd3,
    MOP_V_HI    = 4'd4,
    MOP_P_LO    = 4'd5,
    MOP_P_HI    = 4'd6,
    MOP_S_LO    = 4'd7,
    MOP_S_HI    = 4'd8
  } pl_mop_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  symbol;
    logic [23:0] quantity;
    logic [31:0] price;
    logic [31:0] order_id;
    logic [47:0] timestamp;
  } pl_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        echo_order_id;
    logic [9:0]         echo_symbol;
    logic [62:0]        trade_commission;
    logic [62:0]        buy_commission_share;
    logic signed [63:0] trade_pnl;
    logic signed [63:0] unrealized_value;
    logic signed [63:0] cash_balance;
    logic signed [63:0] equity_value;
    logic [47:0]        echo_timestamp;
  } pl_rsp_t;

  typedef struct packed {
    logic [31:0] held;
    logic [47:0] avg;
    logic [63:0] realized;
    logic [63:0] unrealized;
    logic [63:0] accrued;
    logic [31:0] last;
  } pl_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    pl_entry_t         wdata;
  } pl_ram_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } pl_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } pl_div_rsp_t;

  typedef struct packed {
    logic               load;
    logic signed [63:0] initial_cash;
    logic [23:0]        fee_rate;
  } pl_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pl_table_ram.sv =====
// ----------------------------------------------------------------------------
// Position table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pl_table_ram import pl_pkg::*; (
  input  logic        clk_i,
  input  pl_ram_req_t req_i,
  output pl_entry_t   rdata_o
);

  pl_entry_t mem_q [SYMBOL_COUNT];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pl_divider.sv =====
// ----------------------------------------------------------------------------
// Position ledger divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pl_divider import pl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pl_div_req_t req_i,
  output pl_div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_Q_W-1:0]   quot_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 take;

  assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
  assign take   = (rem_sh >= (DIV_DEN_W+1)'(den_q));
  assign diff   = rem_sh - (DIV_DEN_W+1)'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
      rem_q  <= take ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quot_q <= {quot_q[DIV_Q_W-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pl_core.sv =====
// ----------------------------------------------------------------------------
// Position ledger core
// Sequencer with a shared multiplier that reads, updates and writes back one
// table entry per request, and walks the table for equity.
// ----------------------------------------------------------------------------
`default_nettype none

module pl_core import pl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pl_req_t     in_req_i,
  input  pl_cfg_t     cfg_i,
  output logic        res_valid_o,
  input  logic        res_take_i,
  output pl_rsp_t     res_o,
  output pl_ram_req_t ram_req_o,
  input  pl_entry_t   ram_rdata_i,
  output pl_div_req_t div_req_o,
  input  pl_div_rsp_t div_rsp_i
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_WRITE = 8'b0010_0000,
    ST_WALK  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } pl_state_e;

  pl_state_e         state_q, state_d;
  logic [CNT_W-1:0]  clr_cnt_q;
  logic [CNT_W-1:0]  walk_cnt_q;
  logic              rv1_q, rv2_q;
  pl_mop_e           mop_q;
  logic              phase_q;
  logic              div_started_q;
  logic [63:0]       cash_q, cash_d;
  logic [63:0]       equity_q;

  pl_req_t           req_q;
  logic              in_range_q;
  pl_entry_t         ent_q;
  logic              neg_q;
  logic [47:0]       mag_q;
  logic [63:0]       prod_q;
  logic [55:0]       cost_q;
  logic [79:0]       fee_acc_q;
  logic [80:0]       v_acc_q;
  logic [79:0]       p_acc_q;
  logic [87:0]       s_acc_q;
  pl_rsp_t           rsp_q;

  logic              accept;
  logic              in_range_now;
  logic              walk_issue;
  logic              walk_end;
  logic [31:0]       mul_a, mul_b;
  logic [31:0]       pm;
  logic [47:0]       p16;
  logic              ld_neg;
  logic [32:0]       nq;
  logic              buy_ok, sell_ok, need_div;
  logic [63:0]       fee64, cost64, pr_lo, profit_v, share_v, unreal_v;
  pl_entry_t         nent;
  logic              wr_en;
  pl_rsp_t           wr_rsp, walk_rsp;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign in_range_now = (RANGE_W'(in_req_i.symbol) < RANGE_W'(SYMBOL_COUNT));
  assign walk_issue   = (state_q == ST_WALK) && (walk_cnt_q != CNT_W'(SYMBOL_COUNT));
  assign walk_end     = (state_q == ST_WALK) && !walk_issue && !rv1_q && !rv2_q;

  assign nq       = {1'b0, ent_q.held} + {9'b0, req_q.quantity};
  assign buy_ok   = (req_q.command == CMD_BUY) && !nq[32];
  assign sell_ok  = (req_q.command == CMD_SELL) && ({8'b0, req_q.quantity} <= ent_q.held);
  assign need_div = in_range_q && ((buy_ok && (nq != 33'd0)) ||
                                   (sell_ok && (ent_q.held != 32'd0)));
  assign pm       = (req_q.command == CMD_SELL) ? {8'b0, req_q.quantity} : ent_q.held;

  assign p16    = {req_q.price, 16'h0};
  assign ld_neg = (p16 < ram_rdata_i.avg);

  assign div_req_o.start = (state_q == ST_DIV) && need_div && !div_started_q;
  assign div_req_o.num   = (req_q.command == CMD_BUY) ? DIV_NUM_W'(v_acc_q) : s_acc_q;
  assign div_req_o.den   = (req_q.command == CMD_BUY) ? nq[31:0] : ent_q.held;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_WALK) begin
      mul_a = ram_rdata_i.held;
      mul_b = ram_rdata_i.last;
    end else begin
      unique case (mop_q)
        MOP_COST: begin
          mul_a = req_q.price;
          mul_b = {8'b0, req_q.quantity};
        end
        MOP_FEE_LO: begin
          mul_a = {4'b0, cost_q[27:0]};
          mul_b = {8'b0, cfg_i.fee_rate};
        end
        MOP_FEE_HI: begin
          mul_a = {4'b0, cost_q[55:28]};
          mul_b = {8'b0, cfg_i.fee_rate};
        end
        MOP_V_LO: begin
          mul_a = {8'b0, ent_q.avg[23:0]};
          mul_b = ent_q.held;
        end
        MOP_V_HI: begin
          mul_a = {8'b0, ent_q.avg[47:24]};
          mul_b = ent_q.held;
        end
        MOP_P_LO: begin
          mul_a = {8'b0, mag_q[23:0]};
          mul_b = pm;
        end
        MOP_P_HI: begin
          mul_a = {8'b0, mag_q[47:24]};
          mul_b = pm;
        end
        MOP_S_LO: begin
          mul_a = ent_q.accrued[31:0];
          mul_b = {8'b0, req_q.quantity};
        end
        MOP_S_HI: begin
          mul_a = ent_q.accrued[63:32];
          mul_b = {8'b0, req_q.quantity};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    fee64  = {8'b0, fee_acc_q[79:24]};
    cost64 = {8'b0, cost_q};
    pr_lo  = p_acc_q[79:16];
    if (neg_q) begin
      profit_v = (pr_lo > PL_MIN64) ? PL_MIN64 : (64'd0 - pr_lo);
    end else begin
      profit_v = (pr_lo > PL_MAX63) ? PL_MAX63 : pr_lo;
    end
    share_v  = (ent_q.held != 32'd0) ? div_rsp_i.quot : ent_q.accrued;
    unreal_v = (ent_q.held != 32'd0) ? profit_v : 64'd0;
    nent     = ent_q;
    wr_en    = 1'b0;
    cash_d   = cash_q;

    wr_rsp                      = '0;
    wr_rsp.status               = ST_OK;
    wr_rsp.echo_order_id        = (req_q.command == CMD_BUY || req_q.command == CMD_SELL) ?
                                  req_q.order_id : 32'd0;
    wr_rsp.echo_symbol          = req_q.symbol;
    wr_rsp.echo_timestamp       = req_q.timestamp;

    if (in_range_q) begin
      unique case (req_q.command)
        CMD_BUY: begin
          if (nq[32]) begin
            wr_rsp.status = ST_OVERFLOW;
          end else begin
            wr_en = 1'b1;
            if (nq != 33'd0) begin
              nent.avg = div_rsp_i.quot[47:0];
            end
            nent.held    = nq[31:0];
            nent.accrued = ent_q.accrued + fee64;
            nent.last    = req_q.price;
            cash_d       = cash_q - (cost64 + fee64);
            wr_rsp.trade_commission = fee64[62:0];
          end
        end
        CMD_SELL: begin
          if (!sell_ok) begin
            wr_rsp.status = ST_OVERSELL;
          end else begin
            wr_en         = 1'b1;
            nent.held     = ent_q.held - {8'b0, req_q.quantity};
            nent.accrued  = ent_q.accrued - share_v;
            nent.realized = ent_q.realized + profit_v;
            nent.last     = req_q.price;
            if (nent.held == 32'd0) begin
              nent.avg     = '0;
              nent.accrued = '0;
            end
            cash_d = cash_q + (cost64 - fee64);
            wr_rsp.trade_commission     = fee64[62:0];
            wr_rsp.buy_commission_share = share_v[62:0];
            wr_rsp.trade_pnl            = profit_v;
          end
        end
        CMD_PRICE: begin
          wr_en           = 1'b1;
          nent.last       = req_q.price;
          nent.unrealized = unreal_v;
          wr_rsp.unrealized_value = unreal_v;
        end
        CMD_EQUITY: begin
          wr_en = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    wr_rsp.cash_balance = cash_d;
  end

  always_comb begin
    walk_rsp                = '0;
    walk_rsp.status         = ST_OK;
    walk_rsp.echo_symbol    = req_q.symbol;
    walk_rsp.cash_balance   = cash_q;
    walk_rsp.equity_value   = equity_q;
    walk_rsp.echo_timestamp = req_q.timestamp;
  end

  always_comb begin
    ram_req_o.we    = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && wr_en);
    ram_req_o.waddr = (state_q == ST_CLEAR) ? clr_cnt_q[ADDR_W-1:0] : ADDR_W'(req_q.symbol);
    ram_req_o.wdata = (state_q == ST_CLEAR) ? '0 : nent;
    ram_req_o.raddr = (state_q == ST_WALK) ? walk_cnt_q[ADDR_W-1:0] : ADDR_W'(in_req_i.symbol);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CNT_W'(SYMBOL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!in_range_now) begin
            state_d = ST_WRITE;
          end else if (in_req_i.command == CMD_EQUITY) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (phase_q && (mop_q == MOP_S_HI)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!need_div || (div_started_q && div_rsp_i.done)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      walk_cnt_q    <= '0;
      rv1_q         <= 1'b0;
      rv2_q         <= 1'b0;
      mop_q         <= MOP_COST;
      phase_q       <= 1'b0;
      div_started_q <= 1'b0;
      cash_q        <= '0;
      equity_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_LOAD) begin
        mop_q   <= MOP_COST;
        phase_q <= 1'b0;
      end else if (state_q == ST_MUL) begin
        phase_q <= !phase_q;
        if (phase_q && (mop_q != MOP_S_HI)) begin
          mop_q <= pl_mop_e'(mop_q + 4'd1);
        end
      end
      if (state_q == ST_MUL) begin
        div_started_q <= 1'b0;
      end else if (div_req_o.start) begin
        div_started_q <= 1'b1;
      end
      if (accept) begin
        walk_cnt_q <= '0;
        rv1_q      <= 1'b0;
        rv2_q      <= 1'b0;
      end else begin
        rv1_q <= walk_issue;
        rv2_q <= rv1_q;
        if (walk_issue) begin
          walk_cnt_q <= walk_cnt_q + CNT_W'(1);
        end
      end
      if (cfg_i.load) begin
        cash_q   <= cfg_i.initial_cash;
        equity_q <= cfg_i.initial_cash;
      end else begin
        if (state_q == ST_WRITE) begin
          cash_q <= cash_d;
        end
        if (accept && in_range_now && (in_req_i.command == CMD_EQUITY)) begin
          equity_q <= cash_q;
        end else if (rv2_q && (state_q == ST_WALK)) begin
          equity_q <= equity_q + prod_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      req_q      <= in_req_i;
      in_range_q <= in_range_now;
    end
    if (state_q == ST_LOAD) begin
      ent_q <= ram_rdata_i;
      neg_q <= ld_neg;
      mag_q <= ld_neg ? (ram_rdata_i.avg - p16) : (p16 - ram_rdata_i.avg);
    end
    if ((state_q == ST_MUL) && phase_q) begin
      unique case (mop_q)
        MOP_COST:   cost_q    <= prod_q[55:0];
        MOP_FEE_LO: fee_acc_q <= 80'(prod_q[51:0]);
        MOP_FEE_HI: fee_acc_q <= fee_acc_q + 80'({prod_q[51:0], 28'b0});
        MOP_V_LO:   v_acc_q   <= 81'(prod_q[55:0]) + 81'({cost_q, 16'h0});
        MOP_V_HI:   v_acc_q   <= v_acc_q + 81'({prod_q[55:0], 24'b0});
        MOP_P_LO:   p_acc_q   <= 80'(prod_q[55:0]);
        MOP_P_HI:   p_acc_q   <= p_acc_q + 80'({prod_q[55:0], 24'b0});
        MOP_S_LO:   s_acc_q   <= 88'(prod_q[55:0]);
        MOP_S_HI:   s_acc_q   <= s_acc_q + {prod_q[55:0], 32'b0};
        default:    cost_q    <= cost_q;
      endcase
    end
    if (state_q == ST_WRITE) begin
      rsp_q <= wr_rsp;
    end else if (walk_end) begin
      rsp_q <= walk_rsp;
    end
  end

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/position_ledger_top.sv =====
// ----------------------------------------------------------------------------
// Position ledger
// Per-symbol average-cost position keeping with a cash balance.
// ----------------------------------------------------------------------------
// Requests arrive on in_req_i with in_valid_i and are taken when in_stall_o is
// low; one result leaves on out_rsp_o with out_valid_o, held while out_stall_i
// is high. A result waiting in the output register does not block the next
// request. The APB port sets the starting cash and the commission rate.
// Requests are handled one at a time. A price update, a rejected fill or a
// fill that needs no division goes from load through the multiplier steps to
// write. A fill that divides also waits for the bit-serial divider for the
// average price and commission share (88 quotient bits, one per cycle). An
// equity request walks the whole table, one table entry read per cycle.
// After reset the block clears every entry of the position table, one entry
// per cycle, with in_stall_o high; cash, equity and both registers reset to
// zero. A stalled receiver holds the output register and, once the next
// result is ready, the sequencer waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module position_ledger_top import pl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pl_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pl_rsp_t               out_rsp_o
);

  logic [63:0]  initial_cash_q;
  logic [23:0]  rate_q;
  logic         apb_wr;
  pl_reg_e      reg_sel;
  pl_cfg_t      cfg;
  logic         res_valid;
  logic         res_take;
  pl_rsp_t      res;
  logic         out_valid_q;
  pl_rsp_t      out_rsp_q;
  pl_ram_req_t  ram_req;
  pl_entry_t    ram_rdata;
  pl_div_req_t  div_req;
  pl_div_rsp_t  div_rsp;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite && pready;
  assign reg_sel = pl_reg_e'(paddr[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_cash_q <= '0;
      rate_q         <= '0;
    end else if (apb_wr) begin
      unique case (reg_sel)
        REG_INITIAL_CASH: initial_cash_q <= pwdata;
        REG_COMMISSION:   rate_q         <= pwdata[23:0];
        default:          rate_q         <= rate_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INITIAL_CASH: prdata = initial_cash_q;
      REG_COMMISSION:   prdata = {40'b0, rate_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg.load         = apb_wr && (reg_sel == REG_INITIAL_CASH);
  assign cfg.initial_cash = pwdata;
  assign cfg.fee_rate     = rate_q;

  pl_table_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  pl_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pl_checker.sv =====
// ----------------------------------------------------------------------------
// Position ledger checker
// Port-level properties of the position ledger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_ledger_top_defines.svh"

module pl_checker import pl_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input pl_rsp_t out_rsp_o
);

  logic rsp_quiet;

  assign rsp_quiet = (out_rsp_o.trade_commission == '0) &&
                     (out_rsp_o.buy_commission_share == '0) &&
                     (out_rsp_o.trade_pnl == '0) &&
                     (out_rsp_o.unrealized_value == '0) &&
                     (out_rsp_o.equity_value == '0);

  `PL_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
  `PL_ASSERT(a_reject_clean, clk_i, rst_ni, out_valid_o && out_rsp_o.status != ST_OK |-> rsp_quiet)
  `PL_ASSERT(a_clear_after_reset, clk_i, rst_ni, $past(!rst_ni) |-> in_stall_o && !out_valid_o)
  `PL_ASSERT_ALWAYS(a_stall_in_reset, clk_i, !rst_ni |-> in_stall_o)

endmodule

bind position_ledger_top pl_checker u_pl_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Position ledger testbench
// Drives fills, price updates and equity requests through the request channel,
// predicts every result from a local copy of the position table and cash, and
// checks each result field by field. Starting cash and commission rate are
// written over APB between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb;
  import pl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 1100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  pl_req_t               in_req_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pl_rsp_t               out_rsp_o;

  position_ledger_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Local copy of the ledger.
  logic [31:0] led_held [SYMBOL_COUNT];
  logic [47:0] led_avg [SYMBOL_COUNT];
  logic [63:0] led_realized [SYMBOL_COUNT];
  logic [63:0] led_unreal [SYMBOL_COUNT];
  logic [63:0] led_accrued [SYMBOL_COUNT];
  logic [31:0] led_last [SYMBOL_COUNT];
  logic [63:0] led_cash;
  logic [63:0] led_equity;
  logic [23:0] led_rate;

  pl_rsp_t     pending_rsp [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  initial begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      led_held[i] = '0;
      led_avg[i] = '0;
      led_realized[i] = '0;
      led_unreal[i] = '0;
      led_accrued[i] = '0;
      led_last[i] = '0;
    end
    led_cash = '0;
    led_equity = '0;
    led_rate = '0;
  end

  function automatic logic [63:0] profit_of(logic [31:0] px, logic [47:0] avg,
                                            logic [63:0] m);
    logic [63:0]  p16;
    logic [63:0]  mag;
    logic [127:0] pr;
    logic [127:0] sh;
    logic         neg;
    p16 = {16'b0, px, 16'b0};
    neg = p16 < {16'b0, avg};
    mag = neg ? ({16'b0, avg} - p16) : (p16 - {16'b0, avg});
    pr = {64'b0, mag} * {64'b0, m};
    sh = pr >> 16;
    if (neg) begin
      if (sh > 128'h8000_0000_0000_0000) return PL_MIN64;
      return -sh[63:0];
    end
    if (sh > {64'b0, PL_MAX63}) return PL_MAX63;
    return sh[63:0];
  endfunction

  function automatic pl_rsp_t ledger_apply(pl_req_t r);
    pl_rsp_t      o;
    logic [9:0]   s;
    logic [63:0]  cost;
    logic [127:0] prod;
    logic [63:0]  fee;
    logic [32:0]  nq;
    logic [127:0] v;
    logic [127:0] q;
    logic [63:0]  share;
    logic [63:0]  pnl;
    logic [31:0]  held;
    o = '0;
    s = r.symbol;
    o.echo_order_id = (r.command == CMD_BUY || r.command == CMD_SELL) ? r.order_id : '0;
    o.echo_symbol = s;
    o.echo_timestamp = r.timestamp;
    held = led_held[s];
    cost = {32'b0, r.price} * {40'b0, r.quantity};
    prod = {64'b0, cost} * {104'b0, led_rate};
    fee = prod[87:24];
    case (r.command)
      CMD_BUY: begin
        nq = {1'b0, held} + {9'b0, r.quantity};
        if (nq[32]) begin
          o.status = ST_OVERFLOW;
        end else begin
          if (nq != 0) begin
            v = {80'b0, led_avg[s]} * {96'b0, held} + ({64'b0, cost} << 16);
            q = v / {95'b0, nq};
            led_avg[s] = q[47:0];
          end
          led_held[s] = nq[31:0];
          led_cash = led_cash - (cost + fee);
          led_accrued[s] = led_accrued[s] + fee;
          led_last[s] = r.price;
          o.trade_commission = fee[62:0];
        end
      end
      CMD_SELL: begin
        if ({8'b0, r.quantity} > held) begin
          o.status = ST_OVERSELL;
        end else begin
          pnl = profit_of(r.price, led_avg[s], {40'b0, r.quantity});
          if (held != 0) begin
            q = ({64'b0, led_accrued[s]} * {104'b0, r.quantity}) / {96'b0, held};
            share = q[63:0];
          end else begin
            share = led_accrued[s];
          end
          led_accrued[s] = led_accrued[s] - share;
          held = held - {8'b0, r.quantity};
          led_held[s] = held;
          led_realized[s] = led_realized[s] + pnl;
          led_cash = led_cash + (cost - fee);
          if (held == 0) begin
            led_avg[s] = '0;
            led_accrued[s] = '0;
          end
          led_last[s] = r.price;
          o.trade_commission = fee[62:0];
          o.buy_commission_share = share[62:0];
          o.trade_pnl = pnl;
        end
      end
      CMD_PRICE: begin
        led_last[s] = r.price;
        led_unreal[s] = (held != 0) ? profit_of(r.price, led_avg[s], {32'b0, held}) : '0;
        o.unrealized_value = led_unreal[s];
      end
      default: begin
        led_equity = led_cash;
        for (int i = 0; i < SYMBOL_COUNT; i++)
          led_equity = led_equity + {32'b0, led_held[i]} * {32'b0, led_last[i]};
        o.equity_value = led_equity;
      end
    endcase
    o.cash_balance = led_cash;
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(pl_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    pending_rsp.push_back(ledger_apply(r));
  endtask

  task automatic send_fields(pl_cmd_e c, int unsigned sym, logic [23:0] qty,
                             logic [31:0] px);
    pl_req_t r;
    r.command = c;
    r.symbol = sym[9:0];
    r.quantity = qty;
    r.price = px;
    r.order_id = $urandom();
    r.timestamp = 48'({$urandom(), $urandom()});
    send_request(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(pl_reg_e idx, logic [63:0] value);
    wait_drained();
    repeat (30) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_INITIAL_CASH) begin
      led_cash = value;
      led_equity = value;
    end else begin
      led_rate = value[23:0];
    end
  endtask

  task automatic test_empty_table();
    send_fields(CMD_EQUITY, 0, '0, '0);
    send_fields(CMD_PRICE, 3, '0, 32'hFFFF_FFFF);
    send_fields(CMD_BUY, 5, '0, 32'd1000);
    send_fields(CMD_SELL, 6, '0, 32'd1000);
    send_fields(CMD_SELL, 7, 24'd1, 32'd10);
  endtask

  task automatic test_directed_fills();
    pl_req_t r;
    send_fields(CMD_BUY, 1, 24'd100, 32'd5000);
    send_fields(CMD_BUY, 1, 24'd37, 32'd5123);
    send_fields(CMD_PRICE, 1, '0, 32'd4000);
    send_fields(CMD_PRICE, 1, '0, 32'hFFFF_FFFF);
    send_fields(CMD_SELL, 1, 24'd50, '0);
    send_fields(CMD_SELL, 1, 24'd200, 32'd6000);
    send_fields(CMD_SELL, 1, 24'd87, 32'd7000);
    send_fields(CMD_BUY, 2, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_fields(CMD_SELL, 2, 24'hFF_FFFF, '0);
    send_fields(CMD_SELL, 2, '0, 32'd3);
    r.command = CMD_BUY;
    r.symbol = 10'h3FF;
    r.quantity = 24'hFF_FFFF;
    r.price = 32'hFFFF_FFFF;
    r.order_id = 32'hFFFF_FFFF;
    r.timestamp = 48'hFFFF_FFFF_FFFF;
    send_request(r);
    r.command = CMD_SELL;
    r.quantity = 24'd1;
    r.price = '0;
    r.order_id = '0;
    r.timestamp = '0;
    send_request(r);
    send_fields(CMD_EQUITY, 0, '0, '0);
  endtask

  task automatic test_position_overflow();
    for (int i = 0; i < 256; i++) send_fields(CMD_BUY, 1022, 24'hFF_FFFF, 32'd2);
    send_fields(CMD_BUY, 1022, 24'hFF_FFFF, 32'd2);
    send_fields(CMD_BUY, 1022, 24'd255, 32'd3);
    send_fields(CMD_BUY, 1022, 24'd1, 32'd3);
    send_fields(CMD_PRICE, 1022, '0, 32'hFFFF_FFFF);
    send_fields(CMD_SELL, 1022, 24'hFF_FFFF, 32'd1);
    send_fields(CMD_EQUITY, 0, '0, '0);
  endtask

  task automatic test_random_traffic(int unsigned count);
    pl_req_t     r;
    int unsigned k;
    logic [31:0] cap;
    for (int n = 0; n < count; n++) begin
      r.order_id = $urandom();
      r.timestamp = 48'({$urandom(), $urandom()});
      r.symbol = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 7)) : 10'($urandom());
      k = $urandom_range(0, 2);
      r.price = (k == 0) ? $urandom() : (k == 1) ? $urandom_range(0, 100000) :
                32'($urandom_range(0, 255));
      k = $urandom_range(0, 99);
      if (k < 42) begin
        r.command = CMD_BUY;
        k = $urandom_range(0, 9);
        r.quantity = (k < 6) ? 24'($urandom_range(0, 1000)) : (k < 9) ? 24'($urandom()) : '0;
      end else if (k < 78) begin
        r.command = CMD_SELL;
        cap = (led_held[r.symbol] > 32'hFF_FFFF) ? 32'hFF_FFFF : led_held[r.symbol];
        k = $urandom_range(0, 99);
        if (k < 15) r.quantity = 24'($urandom());
        else if (k < 30) r.quantity = cap[23:0];
        else r.quantity = 24'($urandom_range(0, cap));
      end else if (k < 97) begin
        r.command = CMD_PRICE;
        r.quantity = 24'($urandom());
      end else begin
        r.command = CMD_EQUITY;
        r.quantity = 24'($urandom());
      end
      send_request(r);
    end
  endtask

  // Receiver back-pressure: runs of free cycles with short and a few long stalls.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_stall_i <= 1'b0;
          stall_left <= $urandom_range(1, 40);
        end
        9: begin
          out_stall_i <= 1'b1;
          stall_left <= $urandom_range(20, 80);
        end
        default: begin
          out_stall_i <= 1'b1;
          stall_left <= $urandom_range(1, 3);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    pl_rsp_t e;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %p", out_rsp_o);
      end else begin
        e = pending_rsp.pop_front();
        if (out_rsp_o.status !== e.status
            || out_rsp_o.echo_order_id !== e.echo_order_id
            || out_rsp_o.echo_symbol !== e.echo_symbol
            || out_rsp_o.trade_commission !== e.trade_commission
            || out_rsp_o.buy_commission_share !== e.buy_commission_share
            || out_rsp_o.trade_pnl !== e.trade_pnl
            || out_rsp_o.unrealized_value !== e.unrealized_value
            || out_rsp_o.cash_balance !== e.cash_balance
            || out_rsp_o.equity_value !== e.equity_value
            || out_rsp_o.echo_timestamp !== e.echo_timestamp) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("expected %p\nactual   %p", e, out_rsp_o);
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_directed_fills();
    write_register(REG_COMMISSION, 24'hFF_FFFF);
    write_register(REG_INITIAL_CASH, PL_MIN64);
    test_directed_fills();
    test_position_overflow();
    write_register(REG_INITIAL_CASH, PL_MAX63);
    write_register(REG_COMMISSION, 24'h00_4000);
    test_random_traffic(300);
    write_register(REG_COMMISSION, '0);
    write_register(REG_INITIAL_CASH, '0);
    test_random_traffic(250);
    write_register(REG_COMMISSION, 24'($urandom()));
    write_register(REG_INITIAL_CASH, {$urandom(), $urandom()});
    test_random_traffic(400);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
